// ----- hdl/mtrg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtrg_pkg: shared constants, types and functions
// Word widths, MT19937 constants, feed control struct, twist and temper logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtrg_pkg;

  localparam int WORD_W        = 32;
  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int CNT_W         = $clog2(STATE_WORDS);

  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

  // Command codes on the input word
  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Source of the word pushed into the tail of the cell row
  localparam logic [1:0] FEED_TWIST = 2'd0;
  localparam logic [1:0] FEED_SEED  = 2'd1;
  localparam logic [1:0] FEED_INIT  = 2'd2;

  typedef struct packed {
    logic [1:0]       sel;
    logic [CNT_W-1:0] fill_idx;
  } feed_ctrl_t;

  function automatic logic [WORD_W-1:0] twist_word(
    input logic [WORD_W-1:0] upper,
    input logic [WORD_W-1:0] lower,
    input logic [WORD_W-1:0] mid
  );
    logic [WORD_W-1:0] joined;
    logic [WORD_W-1:0] mixed;
    joined = {upper[WORD_W-1], lower[WORD_W-2:0]};
    mixed  = joined >> 1;
    if (joined[0]) begin
      mixed = mixed ^ TWIST_MATRIX;
    end
    return mid ^ mixed;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mtrg_if.sv -----
// ----------------------------------------------------------------------------
// mtrg_if: valid/ready channels of the generator
// Command channel (command, seed word) and result channel (random word).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mtrg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [mtrg_pkg::WORD_W-1:0] seed_value;

  modport source (output valid, output command, output seed_value, input ready);
  modport sink   (input valid, input command, input seed_value, output ready);
endinterface

interface mtrg_out_if;
  logic                        valid;
  logic                        ready;
  logic [mtrg_pkg::WORD_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/mtrg_cell.sv -----
// ----------------------------------------------------------------------------
// mtrg_cell: one state word of the twister row
// Takes the word of its right neighbor whenever the row advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtrg_cell (
  input  wire logic                        clk,
  input  wire logic                        shift_en,
  input  wire logic [mtrg_pkg::WORD_W-1:0] word_in,
  output logic      [mtrg_pkg::WORD_W-1:0] word_out
);
  import mtrg_pkg::*;

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= word_in;
    end
  end

  assign word_out = word_r;

endmodule

`default_nettype wire

// ----- hdl/mtrg_feed.sv -----
// ----------------------------------------------------------------------------
// mtrg_feed: tail feed of the cell row
// Builds the next state word (seed, init recurrence or twist) and the tempered twist word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtrg_feed (
  input  wire logic                        [mtrg_pkg::WORD_W-1:0] head_word,
  input  wire logic                        [mtrg_pkg::WORD_W-1:0] next_word,
  input  wire logic                        [mtrg_pkg::WORD_W-1:0] mid_word,
  input  wire logic                        [mtrg_pkg::WORD_W-1:0] tail_word,
  input  wire logic                        [mtrg_pkg::WORD_W-1:0] seed_value,
  input  wire mtrg_pkg::feed_ctrl_t                               ctrl,
  output logic                             [mtrg_pkg::WORD_W-1:0] new_word,
  output logic                             [mtrg_pkg::WORD_W-1:0] tempered_word
);
  import mtrg_pkg::*;

  logic [WORD_W-1:0] init_base;
  logic [WORD_W-1:0] init_prod;
  logic [WORD_W-1:0] init_word;
  logic [WORD_W-1:0] twisted;

  // Init recurrence: low word of the product, plus the word number
  assign init_base = tail_word ^ (tail_word >> 30);
  assign init_prod = init_base * INIT_MULT;
  assign init_word = init_prod + WORD_W'(ctrl.fill_idx);

  assign twisted = twist_word(head_word, next_word, mid_word);

  always_comb begin
    unique case (ctrl.sel)
      FEED_SEED: new_word = seed_value;
      FEED_INIT: new_word = init_word;
      default:   new_word = twisted;
    endcase
  end

  assign tempered_word = temper(twisted);

endmodule

`default_nettype wire

// ----- hdl/mt19937_random_generator_unit.sv -----
// ----------------------------------------------------------------------------
// mt19937_random_generator_unit: MT19937 32-bit generator on a row of cells
// Output: a draw's word is registered in the output register in the cycle after accept.
// Throughput: one draw per cycle while the result is taken; a seed holds the input for
//   the seed word plus 623 init steps through the single init multiplier.
// Reset: synchronous; cells are not cleared, draws return zero until a seed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mt19937_random_generator_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  mtrg_in_if.sink   in_word,
  mtrg_out_if.source out_word
);
  import mtrg_pkg::*;

  // The 624 state words sit in a circular row of cells. Cell 0 holds the
  // oldest word; each advance drops it and pushes a fresh word at the tail.
  // During a twist the fresh word is built from cells 0, 1 and 397, which is
  // exactly the in-place twist done one word at a time: cell 397 already
  // holds a regenerated word once the twist has wrapped past it, and cell 1
  // holds the new word 0 when word 623 is built. So the row needs no index.

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_FILL = 1'b1;

  logic                       state_r;
  logic                       state_nxt;
  logic [CNT_W-1:0]           fill_cnt_r;
  logic [CNT_W-1:0]           fill_cnt_nxt;
  logic                       seeded_r;
  logic                       out_valid_r;
  logic [WORD_W-1:0]          out_data_r;

  logic                       in_take;
  logic                       take_seed;
  logic                       take_draw;
  logic                       shift_en;
  feed_ctrl_t                 ctrl;
  logic [WORD_W-1:0]          new_word;
  logic [WORD_W-1:0]          tempered_word;
  logic [WORD_W-1:0]          cell_q [STATE_WORDS];

  // Take a new word outside of init while the result slot is free or being emptied
  assign in_word.ready = (state_r == ST_RUN) && (!out_valid_r || out_word.ready);
  assign in_take       = in_word.valid && in_word.ready;
  assign take_seed     = in_take && (in_word.command == CMD_SEED);
  assign take_draw     = in_take && (in_word.command == CMD_DRAW);

  // Advance the row on every accepted word and on every init step
  assign shift_en = in_take || (state_r == ST_FILL);

  always_comb begin
    ctrl.fill_idx = fill_cnt_r;
    if (state_r == ST_FILL) begin
      ctrl.sel = FEED_INIT;
    end else if (take_seed) begin
      ctrl.sel = FEED_SEED;
    end else begin
      ctrl.sel = FEED_TWIST;
    end
  end

  mtrg_feed u_feed (
    .head_word     (cell_q[0]),
    .next_word     (cell_q[1]),
    .mid_word      (cell_q[MIDDLE_OFFSET]),
    .tail_word     (cell_q[STATE_WORDS-1]),
    .seed_value    (in_word.seed_value),
    .ctrl          (ctrl),
    .new_word      (new_word),
    .tempered_word (tempered_word)
  );

  for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
    if (k == STATE_WORDS - 1) begin : g_tail
      mtrg_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .word_in  (new_word),
        .word_out (cell_q[k])
      );
    end else begin : g_body
      mtrg_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .word_in  (cell_q[k+1]),
        .word_out (cell_q[k])
      );
    end
  end

  // Seed sequencer: the seed word goes in on accept, then 623 init steps
  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    unique case (state_r)
      ST_RUN: begin
        if (take_seed) begin
          state_nxt    = ST_FILL;
          fill_cnt_nxt = CNT_W'(1);
        end
      end
      ST_FILL: begin
        fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
        if (fill_cnt_r == CNT_W'(STATE_WORDS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      fill_cnt_r <= '0;
      seeded_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      if (take_seed) begin
        seeded_r <= 1'b1;
      end
    end
  end

  // Result register: hold until taken; an unseeded draw returns zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_draw) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_draw) begin
      out_data_r <= seeded_r ? tempered_word : '0;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.random_value = out_data_r;

endmodule

`default_nettype wire

// ----- test/tb_mt19937_random_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mt19937_random_generator_unit: self-checking bench for the MT19937 unit
// Feeds seed and draw words over the valid/ready command channel and predicts
// every tempered output word with a behavioral copy of the generator state.
// Random idle bursts on both channels and one long output hold-off, so the
// unit stalls its input. The last part of the run has no idling.
// ----------------------------------------------------------------------------

module tb_mt19937_random_generator_unit;

  import mtrg_pkg::*;

  // The slowest correct run is about 40 seeds, each with its init steps, plus
  // 1700 items with idle bursts on both sides and one long hold-off, so this
  // limit leaves a wide margin.
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 1500;  // cycles the receiver holds off once
  localparam int HOLD_AFTER  = 300;   // draws to accept before that hold-off
  localparam int CALM_ITEMS  = 150;   // last items are sent with no idling
  localparam int ITEM_TARGET = 1700;

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] seed_value;
  } gen_item_t;

  logic clk;
  logic rst_n;

  mtrg_in_if  in_bus ();
  mtrg_out_if out_bus ();

  mt19937_random_generator_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_bus),
    .out_word (out_bus)
  );

  // --------------------------------------------------------------------------
  // Behavioral generator: state words, read index and the predicted words.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] gen_words [STATE_WORDS];
  int unsigned       gen_index;

  gen_item_t         pending_items [$];
  logic [WORD_W-1:0] expected_words [$];

  int  error_count     = 0;
  int  words_checked   = 0;
  int  seeds_taken     = 0;
  int  draws_taken     = 0;
  int  twist_passes    = 0;
  int  run_since_seed  = 0;
  int  longest_run     = 0;
  int  cycle_count     = 0;
  int  gap_left        = 0;
  int  stall_left      = 0;
  bit  long_hold_done  = 1'b0;
  bit  calm            = 1'b0;

  // Start from the reset state: all words zero, index at the end.
  task automatic clear_words();
    for (int k = 0; k < STATE_WORDS; k++) begin
      gen_words[k] = '0;
    end
    gen_index = STATE_WORDS;
  endtask

  // Load the state from one seed word with the usual init recurrence.
  task automatic reseed_words(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] prev;
    gen_words[0] = seed;
    for (int k = 1; k < STATE_WORDS; k++) begin
      prev         = gen_words[k-1];
      gen_words[k] = INIT_MULT * (prev ^ (prev >> 30)) + WORD_W'(k);
    end
    gen_index = STATE_WORDS;
  endtask

  // Regenerate all words in place; later words see the earlier new ones.
  task automatic regenerate_words();
    logic [WORD_W-1:0] joined;
    logic [WORD_W-1:0] mixed;
    for (int k = 0; k < STATE_WORDS; k++) begin
      joined = {gen_words[k][WORD_W-1], gen_words[(k + 1) % STATE_WORDS][WORD_W-2:0]};
      mixed  = joined >> 1;
      if (joined[0]) begin
        mixed = mixed ^ TWIST_MATRIX;
      end
      gen_words[k] = gen_words[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ mixed;
    end
    gen_index    = 0;
    twist_passes = twist_passes + 1;
  endtask

  function automatic logic [WORD_W-1:0] temper_value(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] t;
    t = raw;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // Twist on demand, then hand out the tempered word at the index.
  task automatic draw_word(output logic [WORD_W-1:0] word);
    if (gen_index >= STATE_WORDS) begin
      regenerate_words();
    end
    word      = temper_value(gen_words[gen_index]);
    gen_index = gen_index + 1;
  endtask

  function automatic gen_item_t make_item(input logic cmd, input logic [WORD_W-1:0] val);
    gen_item_t item;
    item.command    = cmd;
    item.seed_value = val;
    return item;
  endfunction

  // Seeds lean on the corners now and then; most are fully random.
  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Command driver: hold a word until it is taken, then send the next one
  // from the pending queue, with random idle bursts until the calm tail.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : command_driver
    gen_item_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (gap_left > 0) begin
        gap_left     <= gap_left - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt                = pending_items.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.command    <= nxt.command;
        in_bus.seed_value <= nxt.seed_value;
        if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(1, 16);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
      calm <= (pending_items.size() <= CALM_ITEMS);
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: short random stalls, plus one long hold-off once enough
  // draws went in, so the output backs up and the command channel stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_receiver
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (!long_hold_done && draws_taken >= HOLD_AFTER) begin
      long_hold_done <= 1'b1;
      stall_left     <= LONG_HOLD - 1;
      out_bus.ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left    <= $urandom_range(0, 15);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: predict on every accepted command word, then compare every
  // accepted output word with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    logic [WORD_W-1:0] want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.command == CMD_SEED) begin
          reseed_words(in_bus.seed_value);
          seeds_taken    <= seeds_taken + 1;
          run_since_seed  = 0;
        end else begin
          draw_word(want);
          expected_words.push_back(want);
          draws_taken    <= draws_taken + 1;
          run_since_seed  = run_since_seed + 1;
          if (run_since_seed > longest_run) begin
            longest_run = run_since_seed;
          end
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        words_checked <= words_checked + 1;
        if (expected_words.size() == 0) begin
          $display("%0t: random_value with nothing expected: expected none, actual %h",
                   $time, out_bus.random_value);
          error_count <= error_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (out_bus.random_value !== want) begin
            $display("%0t: random_value mismatch: expected %h, actual %h",
                     $time, want, out_bus.random_value);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int run_len;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.command     = CMD_SEED;
    in_bus.seed_value  = '0;
    out_bus.ready      = 1'b0;
    clear_words();

    // Draws before any seed: the model state is all zero, so the words are zero.
    // The seed field of a draw is ignored, so drive its corners there too.
    pending_items.push_back(make_item(CMD_DRAW, '1));
    pending_items.push_back(make_item(CMD_DRAW, '0));
    // Classic default seed, then a few draws (the first one twists).
    pending_items.push_back(make_item(CMD_SEED, 32'd5489));
    repeat (3) pending_items.push_back(make_item(CMD_DRAW, $urandom));
    // Seed field extremes.
    pending_items.push_back(make_item(CMD_SEED, '0));
    repeat (2) pending_items.push_back(make_item(CMD_DRAW, $urandom));
    pending_items.push_back(make_item(CMD_SEED, '1));
    repeat (2) pending_items.push_back(make_item(CMD_DRAW, $urandom));
    // Reseed in the middle of a sequence: the next draw twists again.
    pending_items.push_back(make_item(CMD_SEED, 32'h8000_0000));
    repeat (2) pending_items.push_back(make_item(CMD_DRAW, $urandom));
    // Back-to-back seeds: only the second one counts.
    pending_items.push_back(make_item(CMD_SEED, 32'h0000_0001));
    pending_items.push_back(make_item(CMD_SEED, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(CMD_DRAW, $urandom));

    // One long run first so the index wraps and a second twist runs.
    pending_items.push_back(make_item(CMD_SEED, $urandom));
    run_len = $urandom_range(640, 700);
    repeat (run_len) pending_items.push_back(make_item(CMD_DRAW, $urandom));

    // Then mostly seed-plus-draws sequences with random content, some of
    // them broken: a seed with no draws after it, or draws with no reseed.
    while (pending_items.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 4) != 0) begin
        pending_items.push_back(make_item(CMD_SEED, pick_seed()));
      end
      if ($urandom_range(0, 9) != 0) begin
        run_len = $urandom_range(1, 60);
        repeat (run_len) pending_items.push_back(make_item(CMD_DRAW, $urandom));
      end
    end

    // Hold reset, then release it for good.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last command word to be taken and all words to arrive.
    while (pending_items.size() > 0 || in_bus.valid) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    // Watch a little longer for stray output words.
    repeat (20) @(posedge clk);

    $display("Covered %0d seeds and %0d draws, %0d words checked, %0d errors.",
             seeds_taken, draws_taken, words_checked, error_count);
    $display("Longest draw run after a seed: %0d words; %0d full state twists.",
             longest_run, twist_passes);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
